/* rtl/vbcl_pkg.sv */
`default_nettype none
package vbcl_pkg;

    localparam int IN_W    = 104;
    localparam int OUT_W   = 128;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_BILEVEL    = 3'd0;
    localparam t_mode MODE_SIXTEEN    = 3'd1;
    localparam t_mode MODE_SIXTYFOUR  = 3'd2;
    localparam t_mode MODE_RGB444     = 3'd3;
    localparam t_mode MODE_BGR233     = 3'd4;

    localparam logic OP_CTRL      = 1'b0;
    localparam logic OP_VECTOR    = 1'b1;
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_SWAP  = 2'd1;
    localparam logic [1:0] CFG_MIN_X = 2'd2;
    localparam logic [1:0] CFG_MIN_Y = 2'd3;

    typedef struct packed {
        logic        kind;
        logic        two;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [9:0]  inten;
        logic [23:0] color;
        logic [11:0] rx;
        logic [11:0] ry;
    } t_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] grey16(input logic [3:0] c);
        logic [11:0] p;
        p = ({8'd0, c} + 12'd1) * 12'd255;
        return p[11:4];
    endfunction

    function automatic logic [7:0] grey64(input logic [5:0] v);
        logic [13:0] p;
        p = ({8'd0, v} + 14'd1) * 14'd255;
        return p[13:6];
    endfunction

    function automatic logic [7:0] scale15(input logic [3:0] n);
        return {n, n};
    endfunction

    function automatic logic [7:0] scale3(input logic [1:0] n);
        return {n, n, n, n};
    endfunction

    function automatic logic [7:0] scale7(input logic [2:0] n);
        logic [7:0] r;
        case (n)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd36;
            3'd2:    r = 8'd72;
            3'd3:    r = 8'd109;
            3'd4:    r = 8'd145;
            3'd5:    r = 8'd182;
            3'd6:    r = 8'd218;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] dot_inten(input logic [3:0] sh);
        logic [12:0] p;
        p = {9'd0, sh} * 13'd511;
        return p[12:3];
    endfunction

endpackage
`default_nettype wire

/* rtl/vbcl_front.sv */
`default_nettype none
module vbcl_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [15:0]              i_cfg_data,
    input  wire logic                     i_acc,
    input  wire logic [vbcl_pkg::IN_W-1:0] i_tdata,
    input  wire logic                     i_tuser,
    output logic                          o_push,
    output vbcl_pkg::t_rec                o_rec
);

    vbcl_pkg::t_mode r_mode;
    logic            r_swap;
    logic [15:0]     r_min_x, r_min_y;
    logic [23:0]     r_color, n_color;
    logic [7:0]      r_prev_ctrl;
    logic [15:0]     r_prev_ex, r_prev_ey, n_prev_ex, n_prev_ey;
    logic [11:0]     r_saved_x, r_saved_y, n_saved_x, n_saved_y;

    logic [7:0]  data;
    logic [11:0] cx, cy, nx, ny;
    logic [15:0] ax0, ay0, ax1, ay1, sx, sy, ex, ey;
    logic        rising, falling;

    assign data = i_tdata[7:0];
    assign cx   = i_tdata[19:8];
    assign cy   = i_tdata[31:20];
    assign nx   = ~cx;
    assign ny   = ~cy;
    assign ax0  = i_tdata[47:32] - r_min_x;
    assign ay0  = i_tdata[63:48] - r_min_y;
    assign ax1  = i_tdata[79:64] - r_min_x;
    assign ay1  = i_tdata[95:80] - r_min_y;
    assign sx   = r_swap ? ay0 : ax0;
    assign sy   = r_swap ? ax0 : ay0;
    assign ex   = r_swap ? ay1 : ax1;
    assign ey   = r_swap ? ax1 : ay1;

    assign rising  = (data != r_prev_ctrl) && (data != 8'd0);
    assign falling = (data != r_prev_ctrl) && (data == 8'd0);

    always_comb begin
        n_color   = r_color;
        n_saved_x = r_saved_x;
        n_saved_y = r_saved_y;
        n_prev_ex = r_prev_ex;
        n_prev_ey = r_prev_ey;
        o_push    = 1'b0;
        o_rec     = '0;
        if (i_tuser == vbcl_pkg::OP_CTRL) begin
            unique case (r_mode)
                vbcl_pkg::MODE_BILEVEL: begin
                    n_color = data[0] ? 24'h808080 : 24'hffffff;
                end
                vbcl_pkg::MODE_SIXTEEN: begin
                    if (rising) begin
                        n_color = {3{vbcl_pkg::grey16(cx[3:0])}};
                    end
                end
                vbcl_pkg::MODE_SIXTYFOUR: begin
                    if (rising) begin
                        n_color = {3{vbcl_pkg::grey64(nx[7:2])}};
                    end
                end
                vbcl_pkg::MODE_RGB444: begin
                    if (rising) begin
                        n_color = {vbcl_pkg::scale15(nx[3:0]), vbcl_pkg::scale15(nx[7:4]),
                                   vbcl_pkg::scale15(nx[11:8])};
                    end
                end
                vbcl_pkg::MODE_BGR233: begin
                    if (falling) begin
                        n_saved_x = cx;
                        n_saved_y = cy;
                    end
                    if (rising) begin
                        n_color = {vbcl_pkg::scale7(ny[2:0]), vbcl_pkg::scale7(ny[5:3]),
                                   vbcl_pkg::scale3(ny[7:6])};
                        o_push      = 1'b1;
                        o_rec.kind  = vbcl_pkg::KIND_RESTORE;
                        o_rec.color = n_color;
                        o_rec.rx    = r_saved_x;
                        o_rec.ry    = r_saved_y;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            o_push      = 1'b1;
            o_rec.kind  = vbcl_pkg::KIND_LINE;
            o_rec.two   = (sx != r_prev_ex) || (sy != r_prev_ey);
            o_rec.x0    = sx;
            o_rec.y0    = sy;
            o_rec.x1    = ex;
            o_rec.y1    = ey;
            o_rec.inten = ((sx == ex) && (sy == ey)) ? vbcl_pkg::dot_inten(i_tdata[99:96])
                                                     : 10'd255;
            o_rec.color = r_color;
            n_prev_ex   = ex;
            n_prev_ey   = ey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= vbcl_pkg::MODE_BILEVEL;
            r_swap      <= 1'b0;
            r_min_x     <= '0;
            r_min_y     <= '0;
            r_color     <= '0;
            r_prev_ctrl <= '0;
            r_prev_ex   <= '0;
            r_prev_ey   <= '0;
            r_saved_x   <= '0;
            r_saved_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vbcl_pkg::CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                    vbcl_pkg::CFG_SWAP:  r_swap  <= i_cfg_data[0];
                    vbcl_pkg::CFG_MIN_X: r_min_x <= i_cfg_data;
                    default:             r_min_y <= i_cfg_data;
                endcase
            end
            if (i_acc) begin
                r_color   <= n_color;
                r_saved_x <= n_saved_x;
                r_saved_y <= n_saved_y;
                r_prev_ex <= n_prev_ex;
                r_prev_ey <= n_prev_ey;
                if (i_tuser == vbcl_pkg::OP_CTRL) begin
                    r_prev_ctrl <= data;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/vbcl_queue.sv */
`default_nettype none
module vbcl_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire vbcl_pkg::t_rec     i_rec,
    input  wire logic               i_pop,
    output vbcl_pkg::t_rec          o_head,
    output vbcl_pkg::t_q_stat       o_stat
);

    vbcl_pkg::t_rec               r_mem [vbcl_pkg::Q_DEPTH];
    logic [vbcl_pkg::Q_AW-1:0]    r_wp, r_rp;
    logic [vbcl_pkg::Q_AW:0]      r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (vbcl_pkg::Q_AW + 1)'(vbcl_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/vbcl_back.sv */
`default_nettype none
module vbcl_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire vbcl_pkg::t_rec            i_head,
    input  wire vbcl_pkg::t_q_stat         i_stat,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [vbcl_pkg::OUT_W-1:0]     o_data,
    output logic                           o_user,
    output logic                           o_last
);

    logic r_valid, n_valid;
    logic r_second, n_second;
    logic r_last, n_last;
    logic r_user;
    logic [vbcl_pkg::OUT_W-1:0] r_data;
    logic load, emit;

    assign load  = !r_valid || i_ready;
    assign emit  = load && !i_stat.empty;

    always_comb begin
        n_valid  = r_valid && !i_ready;
        n_second = r_second;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (emit) begin
            n_valid = 1'b1;
            if (i_head.two && !r_second) begin
                n_last   = 1'b0;
                n_second = 1'b1;
            end else begin
                n_last   = 1'b1;
                n_second = 1'b0;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_user <= i_head.kind;
            r_data <= {6'd0, i_head.ry, i_head.rx, i_head.color, i_head.inten,
                       i_head.y1, i_head.x1, i_head.y0, i_head.x0};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule
`default_nettype wire

/* rtl/vector_beam_color_latch_top.sv */
// beam colour latch and line emitter of a vector display
// slave channel s_axis_*: one request per cpu colour control write (tuser 0)
// or vector draw command (tuser 1); master channel m_axis_*: line results
// (tuser 0) and register restore results (tuser 1), tlast on the final
// result of each request
// configuration: i_cfg_we writes register i_cfg_idx (0 colour mode, 1 axis
// swap, 2 visible min x, 3 visible min y) with i_cfg_data at the clock edge
// a request's first result passes through a queue entry, then the output register
// throughput: one request per cycle while each gives at most one result and the
// receiver does not stall; a vector whose start is not the previous end point
// gives two results, which leave the output register one after the other
// a four-entry queue of decoded requests sits between the front decoder and
// the output register, so requests keep being accepted while the receiver
// stalls until that queue is full, then s_axis_tready falls
// synchronous active-low reset clears colour, edge history, saved x and y,
// previous end point, configuration and the queue
`default_nettype none
module vector_beam_color_latch_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [15:0]                 i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // control_data, cpu_x, cpu_y, start_x, start_y, end_x, end_y, shift, pad
    input  wire logic [vbcl_pkg::IN_W-1:0]   s_axis_tdata,
    // operation
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // line_x0, line_y0, line_x1, line_y1, intensity, color, restore_x,
    // restore_y, pad
    output logic [vbcl_pkg::OUT_W-1:0]       m_axis_tdata,
    // result_kind
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    vbcl_pkg::t_rec    rec, head;
    vbcl_pkg::t_q_stat stat;
    logic              acc, push, pop;

    assign s_axis_tready = !stat.full;
    assign acc           = s_axis_tvalid && s_axis_tready;

    vbcl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .o_push     (push),
        .o_rec      (rec)
    );

    vbcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc && push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    vbcl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* rtl/vbcl_checker.sv */
`default_nettype none
module vbcl_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [vbcl_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tuser,
    input wire logic                        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_restore_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == vbcl_pkg::KIND_RESTORE) |-> m_axis_tlast)
        else $error("restore result not last");

    a_restore_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == vbcl_pkg::KIND_RESTORE)
        |-> (m_axis_tdata[73:0] == '0))
        else $error("restore result carries line fields");

    a_line_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == vbcl_pkg::KIND_LINE)
        |-> (m_axis_tdata[127:98] == '0))
        else $error("line result carries restore fields");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second line of a pair missing");

endmodule

bind vector_beam_color_latch_top vbcl_checker u_vbcl_checker (.*);
`default_nettype wire
